// File: design/bgmb_pkg.sv
// Shared types and constants for the Bayer grid mean brightness block.
// No dependencies; every other design file imports this package.
package bgmb_pkg;

  localparam int PIXEL_W  = 8;
  localparam int POS_W    = 12;
  localparam int STRIDE_W = 13;
  localparam int BLOCKS_W = 12;
  localparam int WEIGHT_W = 18;
  localparam int PROD_W   = PIXEL_W + WEIGHT_W;
  localparam int SUM_W    = 52;
  localparam int DIVSR_W  = 2 * BLOCKS_W;
  localparam int MEAN_W   = 18;
  localparam int MEAN_SHIFT = 8;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes on the configuration port
  localparam logic [2:0] REG_START_X  = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_STRIDE_X = 3'd2;
  localparam logic [2:0] REG_STRIDE_Y = 3'd3;
  localparam logic [2:0] REG_BLOCKS_X = 3'd4;
  localparam logic [2:0] REG_BLOCKS_Y = 3'd5;

  // Weight class of a pixel handed from front to back
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_B    = 2'd1;
  localparam logic [1:0] CLS_G    = 2'd2;
  localparam logic [1:0] CLS_R    = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]    start_x;
    logic [POS_W-1:0]    start_y;
    logic [STRIDE_W-1:0] stride_x;
    logic [STRIDE_W-1:0] stride_y;
    logic [BLOCKS_W-1:0] blocks_x;
    logic [BLOCKS_W-1:0] blocks_y;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [1:0]         cls;
    logic               eof;
  } qent_t;

  // Position of one axis relative to the grid: before the start, or
  // cell index q and offset r inside the stride.
  typedef struct packed {
    logic                pre;
    logic [POS_W-1:0]    q;
    logic [STRIDE_W-1:0] r;
  } axis_t;

  function automatic logic [STRIDE_W-1:0] eff_stride(logic [STRIDE_W-1:0] s);
    return (s < STRIDE_W'(2)) ? STRIDE_W'(2) : s;
  endfunction

  function automatic logic [BLOCKS_W-1:0] eff_blocks(logic [BLOCKS_W-1:0] n);
    return (n == '0) ? BLOCKS_W'(1) : n;
  endfunction

  function automatic axis_t axis_origin(logic [POS_W-1:0] start);
    axis_t a;
    a.pre = (start != '0);
    a.q   = '0;
    a.r   = '0;
    return a;
  endfunction

  // Advance one position; hit means the new position equals the start.
  function automatic axis_t axis_step(axis_t a, logic hit, logic [STRIDE_W-1:0] s);
    axis_t n;
    n = a;
    if (hit) begin
      n.pre = 1'b0;
      n.q   = '0;
      n.r   = '0;
    end else if (!a.pre) begin
      if (a.r + STRIDE_W'(1) == s) begin
        n.q = a.q + POS_W'(1);
        n.r = '0;
      end else begin
        n.r = a.r + STRIDE_W'(1);
      end
    end
    return n;
  endfunction

  // Offset 0/1 inside a sampled cell, valid flag in bit 1 (set = sampled)
  function automatic logic [1:0] axis_offset(axis_t a, logic [BLOCKS_W-1:0] n);
    logic hit;
    hit = !a.pre && (a.q < n) && (a.r < STRIDE_W'(2));
    return {hit, a.r[0]};
  endfunction

endpackage

// File: design/bgmb_pixel_if.sv
// Pixel channel: valid/ready handshake carrying one Bayer pixel word.
// Depends on bgmb_pkg.
interface bgmb_pixel_if;
  import bgmb_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               end_of_line;
  logic               end_of_frame;

  modport source(output valid, pixel, end_of_line, end_of_frame, input ready);
  modport sink(input valid, pixel, end_of_line, end_of_frame, output ready);
endinterface

// File: design/bgmb_mean_if.sv
// Result channel: valid/ready handshake carrying one mean brightness word.
// Depends on bgmb_pkg.
interface bgmb_mean_if;
  import bgmb_pkg::*;
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_brightness;

  modport source(output valid, mean_brightness, input ready);
  modport sink(input valid, mean_brightness, output ready);
endinterface

// File: design/bgmb_front.sv
// Front end: accepts pixel words, tracks raster position against the grid
// and pushes classified pixels into the queue. Depends on bgmb_pkg, bgmb_pixel_if.
module bgmb_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  bgmb_pixel_if.sink           pix,
  input  bgmb_pkg::cfg_t       cfg,
  input  logic                 cfg_write,
  output logic                 push,
  output bgmb_pkg::qent_t      push_ent,
  input  logic                 q_full
);
  import bgmb_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam logic [CW-1:0] LAST = CW'(MAX_DIM - 1);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] column;
  logic [CW-1:0] row;
  logic [CW-1:0] walk_col;
  logic [CW-1:0] walk_row;
  axis_t         ax;
  axis_t         ay;

  logic [STRIDE_W-1:0] sx, sy;
  logic [BLOCKS_W-1:0] nx, ny;
  logic [1:0]          ox, oy;
  logic [POS_W-1:0]    col_inc, row_inc, wcol_inc, wrow_inc;

  assign sx = eff_stride(cfg.stride_x);
  assign sy = eff_stride(cfg.stride_y);
  assign nx = eff_blocks(cfg.blocks_x);
  assign ny = eff_blocks(cfg.blocks_y);
  assign ox = axis_offset(ax, nx);
  assign oy = axis_offset(ay, ny);

  assign col_inc  = POS_W'(column) + POS_W'(1);
  assign row_inc  = POS_W'(row) + POS_W'(1);
  assign wcol_inc = POS_W'(walk_col) + POS_W'(1);
  assign wrow_inc = POS_W'(walk_row) + POS_W'(1);

  assign pix.ready = (state == ST_RUN) && !q_full;
  assign push      = pix.valid && pix.ready;

  always_comb begin
    push_ent.pixel = pix.pixel;
    push_ent.eof   = pix.end_of_frame;
    if (ox[1] && oy[1]) begin
      if (!ox[0] && !oy[0]) begin
        push_ent.cls = CLS_B;
      end else if (ox[0] && oy[0]) begin
        push_ent.cls = CLS_R;
      end else begin
        push_ent.cls = CLS_G;
      end
    end else begin
      push_ent.cls = CLS_NONE;
    end
  end

  // Raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (push) begin
      if (pix.end_of_frame) begin
        column <= '0;
        row    <= '0;
      end else if (pix.end_of_line) begin
        column <= '0;
        row    <= (row == LAST) ? '0 : row + CW'(1);
      end else begin
        column <= (column == LAST) ? '0 : column + CW'(1);
      end
    end
  end

  // Grid tracking; rebuild it by walking from the origin after a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      walk_col <= '0;
      walk_row <= '0;
      ax       <= '0;
      ay       <= '0;
    end else if (cfg_write) begin
      state <= ST_INIT;
    end else begin
      case (state)
        ST_INIT: begin
          ax       <= axis_origin(cfg.start_x);
          ay       <= axis_origin(cfg.start_y);
          walk_col <= '0;
          walk_row <= '0;
          state    <= ST_WALK;
        end
        ST_WALK: begin
          if (walk_col != column) begin
            walk_col <= walk_col + CW'(1);
            ax       <= axis_step(ax, wcol_inc == cfg.start_x, sx);
          end
          if (walk_row != row) begin
            walk_row <= walk_row + CW'(1);
            ay       <= axis_step(ay, wrow_inc == cfg.start_y, sy);
          end
          if (walk_col == column && walk_row == row) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (push) begin
            if (pix.end_of_frame) begin
              ax <= axis_origin(cfg.start_x);
              ay <= axis_origin(cfg.start_y);
            end else if (pix.end_of_line) begin
              ax <= axis_origin(cfg.start_x);
              if (row == LAST) begin
                ay <= axis_origin(cfg.start_y);
              end else begin
                ay <= axis_step(ay, row_inc == cfg.start_y, sy);
              end
            end else begin
              if (column == LAST) begin
                ax <= axis_origin(cfg.start_x);
              end else begin
                ax <= axis_step(ax, col_inc == cfg.start_x, sx);
              end
            end
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

endmodule

// File: design/bgmb_queue.sv
// Short queue of classified pixels between the front and back ends.
// Depends on bgmb_pkg.
module bgmb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bgmb_pkg::qent_t push_ent,
  output logic            full,
  input  logic            pop,
  output bgmb_pkg::qent_t pop_ent,
  output logic            empty
);
  import bgmb_pkg::*;

  qent_t             ent [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_ent = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: design/bgmb_back.sv
// Back end: weights and accumulates queued pixels, divides by the cell count
// at end of frame and holds the result word. Depends on bgmb_pkg, bgmb_mean_if.
module bgmb_back #(
  parameter int WEIGHT_R = 19595,
  parameter int WEIGHT_G = 19235,
  parameter int WEIGHT_B = 7471
) (
  input  logic            clk,
  input  logic            rst,
  input  bgmb_pkg::cfg_t  cfg,
  input  logic            empty,
  input  bgmb_pkg::qent_t pop_ent,
  output logic            pop,
  bgmb_mean_if.source     mean
);
  import bgmb_pkg::*;

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]           state;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     dvd;
  logic [DIVSR_W-1:0]   divisor;
  logic [DIVSR_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 out_valid;
  logic [MEAN_W-1:0]    out_mean;

  logic [WEIGHT_W-1:0] weight;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_next;
  logic [DIVSR_W:0]    rem_sh;
  logic                q_bit;

  always_comb begin
    case (pop_ent.cls)
      CLS_B:   weight = WEIGHT_W'(WEIGHT_B);
      CLS_G:   weight = WEIGHT_W'(WEIGHT_G);
      CLS_R:   weight = WEIGHT_W'(WEIGHT_R);
      default: weight = '0;
    endcase
  end

  assign prod    = PROD_W'(pop_ent.pixel) * PROD_W'(weight);
  assign sum_add = (SUM_W+1)'(sum) + (SUM_W+1)'(prod);
  // Saturate on carry out of the accumulator
  assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  assign rem_sh = {rem, dvd[SUM_W-1]};
  assign q_bit  = (rem_sh >= (DIVSR_W+1)'(divisor));

  assign pop                  = (state == ST_ACC) && !empty;
  assign mean.valid           = out_valid;
  assign mean.mean_brightness = out_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      sum       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new word, else drop the one just taken
      if (state == ST_FIN && (!out_valid || mean.ready)) begin
        out_valid <= 1'b1;
      end else if (mean.valid && mean.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ACC: begin
          if (pop) begin
            if (pop_ent.eof) begin
              sum   <= '0;
              cnt   <= '0;
              state <= ST_DIV;
            end else begin
              sum <= sum_next;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || mean.ready) begin
            state <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  // Datapath: operand load, restoring division at one quotient bit per cycle, and the saturated result word
  always_ff @(posedge clk) begin
    case (state)
      ST_ACC: begin
        if (pop && pop_ent.eof) begin
          dvd     <= sum_next;
          rem     <= '0;
          divisor <= DIVSR_W'(eff_blocks(cfg.blocks_x)) * DIVSR_W'(eff_blocks(cfg.blocks_y));
        end
      end
      ST_DIV: begin
        rem <= q_bit ? DIVSR_W'(rem_sh - (DIVSR_W+1)'(divisor)) : rem_sh[DIVSR_W-1:0];
        dvd <= {dvd[SUM_W-2:0], q_bit};
      end
      ST_FIN: begin
        if (!out_valid || mean.ready) begin
          if (dvd[SUM_W-1:MEAN_W+MEAN_SHIFT] != '0) begin
            out_mean <= '1;
          end else begin
            out_mean <= dvd[MEAN_W+MEAN_SHIFT-1:MEAN_SHIFT];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/bayer_grid_mean_brightness.sv
// Top level of the Bayer grid mean brightness block: register file and
// front/queue/back wiring. Depends on bgmb_pkg, both channel interfaces,
// bgmb_front, bgmb_queue and bgmb_back.
//
// Pixels of a BGGR mosaic stream in raster order, one word per clock while
// the four-entry queue has room and no grid rebuild is under way. The front
// end tracks column and row against a grid of blocks_x by blocks_y 2x2 cells
// (start_x/start_y, stride_x/stride_y) and tags each pixel B, G, R or
// unsampled; the back end multiplies by the Q2.16 weight and adds into a
// 52-bit saturating accumulator. A word with end_of_frame closes the frame:
// its pixel is summed, then the back end runs a restoring divider by
// blocks_x*blocks_y, one quotient bit per cycle; the queue absorbs pixels of
// the next frame until it is full, and then input stalls until the result is
// loaded into the output register. The result is floor(sum / cells) >> 8,
// saturated to 18 bits (Q10.8), held in an output register until taken.
// After every register write the front end rebuilds its grid position by
// stepping from the origin to the current column and row, one step per
// cycle, and holds input while it walks. Registers sit at byte address 4*i
// in the order start_x, start_y, stride_x, stride_y, blocks_x, blocks_y;
// write them only with no frame result outstanding.
module bayer_grid_mean_brightness #(
  parameter int MAX_DIM  = 4096,
  parameter int WEIGHT_R = 19595,
  parameter int WEIGHT_G = 19235,
  parameter int WEIGHT_B = 7471
) (
  input  logic                         clk,
  input  logic                         rst,
  bgmb_pixel_if.sink                   pix,
  bgmb_mean_if.source                  mean,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bgmb_pkg::PADDR_W-1:0] paddr,
  input  logic [bgmb_pkg::PDATA_W-1:0] pwdata,
  output logic [bgmb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bgmb_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;
  logic [2:0] reg_idx;

  logic  push, q_full, pop, q_empty;
  qent_t push_ent, pop_ent;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[4:2];

  // Register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x  <= '0;
      cfg.start_y  <= '0;
      cfg.stride_x <= STRIDE_W'(2);
      cfg.stride_y <= STRIDE_W'(2);
      cfg.blocks_x <= BLOCKS_W'(1);
      cfg.blocks_y <= BLOCKS_W'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_START_X:  cfg.start_x  <= pwdata[POS_W-1:0];
        REG_START_Y:  cfg.start_y  <= pwdata[POS_W-1:0];
        REG_STRIDE_X: cfg.stride_x <= pwdata[STRIDE_W-1:0];
        REG_STRIDE_Y: cfg.stride_y <= pwdata[STRIDE_W-1:0];
        REG_BLOCKS_X: cfg.blocks_x <= pwdata[BLOCKS_W-1:0];
        REG_BLOCKS_Y: cfg.blocks_y <= pwdata[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_X:  prdata = PDATA_W'(cfg.start_x);
      REG_START_Y:  prdata = PDATA_W'(cfg.start_y);
      REG_STRIDE_X: prdata = PDATA_W'(cfg.stride_x);
      REG_STRIDE_Y: prdata = PDATA_W'(cfg.stride_y);
      REG_BLOCKS_X: prdata = PDATA_W'(cfg.blocks_x);
      REG_BLOCKS_Y: prdata = PDATA_W'(cfg.blocks_y);
      default:      prdata = '0;
    endcase
  end

  // Front: position tracking and classification
  bgmb_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .cfg      (cfg),
    .cfg_write(cfg_write),
    .push     (push),
    .push_ent (push_ent),
    .q_full   (q_full)
  );

  // Queue: lets the front keep taking pixels while the back is busy
  bgmb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ent(push_ent),
    .full    (q_full),
    .pop     (pop),
    .pop_ent (pop_ent),
    .empty   (q_empty)
  );

  // Back: weighting, accumulation, division and result register
  bgmb_back #(
    .WEIGHT_R(WEIGHT_R),
    .WEIGHT_G(WEIGHT_G),
    .WEIGHT_B(WEIGHT_B)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .empty  (q_empty),
    .pop_ent(pop_ent),
    .pop    (pop),
    .mean   (mean)
  );

endmodule

// File: bench/bayer_grid_mean_brightness_tb.sv
// Self-checking bench for bayer_grid_mean_brightness: streams Bayer frames through the
// pixel channel, predicts each frame's weighted mean and checks the result channel.
// Depends on bgmb_pkg, bgmb_pixel_if, bgmb_mean_if and the block itself.
module bayer_grid_mean_brightness_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgmb_pkg::*;

  localparam int          MAX_DIM   = 4096;
  localparam int unsigned WT_R      = 19595;
  localparam int unsigned WT_G      = 19235;
  localparam int unsigned WT_B      = 7471;
  // Settle time after the last frame result: queue, divider and grid rebuild.
  localparam int          DRAIN_LAT = 100;
  localparam int          CYCLE_CAP = 3_000_000;
  localparam int          HOLDOFF   = 600;
  localparam int          RAND_WORDS = 300;

  localparam logic [SUM_W-1:0]  SUM_LIMIT  = '1;
  localparam logic [MEAN_W-1:0] MEAN_LIMIT = '1;

  // One pixel word queued for the driver; drain marks a pause until all
  // frame results are back.
  typedef struct {
    logic [PIXEL_W-1:0] value;
    logic               eol;
    logic               eof;
    bit                 drain;
  } pixel_word_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  bgmb_pixel_if pix_ch();
  bgmb_mean_if  mean_ch();

  bayer_grid_mean_brightness #(
    .MAX_DIM (MAX_DIM),
    .WEIGHT_R(WT_R),
    .WEIGHT_G(WT_G),
    .WEIGHT_B(WT_B)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .pix    (pix_ch),
    .mean   (mean_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state: a private copy of the grid registers plus the scan
  // position and the running weighted sum of the current frame.
  cfg_t                grid_cfg;
  logic [POS_W-1:0]    scan_col;
  logic [POS_W-1:0]    scan_row;
  logic [SUM_W-1:0]    frame_sum;
  logic [MEAN_W-1:0]   expected_means[$];

  pixel_word_t         pending_words[$];
  int unsigned         queued_words;
  int unsigned         error_count;
  int unsigned         cycle_count;

  bit                  pix_taken;
  int unsigned         send_gap;
  int unsigned         send_calm;
  int unsigned         recv_stall;
  int unsigned         recv_calm;
  int unsigned         holdoff_left;
  bit                  holdoff_used;
  bit                  hold_results_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pick an idle stretch: mostly none, some short, a few long. A calm spell
  // forces runs of back-to-back words.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) calm = $urandom_range(30, 150);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Place one axis position on the grid: bit 1 set when it lies inside a
  // sampled cell, bit 0 the offset within the cell.
  function automatic logic [1:0] grid_offset(int unsigned pos, int unsigned start,
                                             int unsigned stride, int unsigned count);
    int unsigned span;
    int unsigned cells;
    int unsigned offs;
    span  = (stride < 2) ? 2 : stride;
    cells = (count == 0) ? 1 : count;
    if (pos < start) return 2'b00;
    offs = pos - start;
    if (offs / span >= cells) return 2'b00;
    if (offs % span >= 2) return 2'b00;
    return {1'b1, (offs % span) == 1};
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endtask

  // Fold one accepted pixel into the frame sum; on end of frame queue the
  // expected mean and clear the scan state.
  task automatic absorb_pixel(input logic [PIXEL_W-1:0] value, input logic eol,
                              input logic eof);
    logic [1:0]            ox;
    logic [1:0]            oy;
    logic [WEIGHT_W-1:0]   weight;
    logic [SUM_W-1:0]      product;
    logic [DIVSR_W-1:0]    cell_count;
    logic [SUM_W-1:0]      quotient;
    ox = grid_offset(scan_col, grid_cfg.start_x, grid_cfg.stride_x, grid_cfg.blocks_x);
    oy = grid_offset(scan_row, grid_cfg.start_y, grid_cfg.stride_y, grid_cfg.blocks_y);
    if (ox[1] && oy[1]) begin
      // BGGR: blue top-left, red bottom-right, green on the diagonal pair
      if (!ox[0] && !oy[0]) weight = WEIGHT_W'(WT_B);
      else if (ox[0] && oy[0]) weight = WEIGHT_W'(WT_R);
      else weight = WEIGHT_W'(WT_G);
      product = SUM_W'(value) * SUM_W'(weight);
      if (product > SUM_LIMIT - frame_sum) frame_sum = SUM_LIMIT;
      else frame_sum = frame_sum + product;
    end
    if (eof) begin
      cell_count = DIVSR_W'((grid_cfg.blocks_x == '0) ? 1 : grid_cfg.blocks_x) *
                   DIVSR_W'((grid_cfg.blocks_y == '0) ? 1 : grid_cfg.blocks_y);
      quotient = (frame_sum / SUM_W'(cell_count)) >> MEAN_SHIFT;
      expected_means.push_back((quotient > SUM_W'(MEAN_LIMIT)) ? MEAN_LIMIT
                                                               : quotient[MEAN_W-1:0]);
      scan_col  = '0;
      scan_row  = '0;
      frame_sum = '0;
    end else if (eol) begin
      scan_col = '0;
      scan_row = (scan_row == POS_W'(MAX_DIM - 1)) ? '0 : scan_row + 1'b1;
    end else begin
      scan_col = (scan_col == POS_W'(MAX_DIM - 1)) ? '0 : scan_col + 1'b1;
    end
  endtask

  // Monitor: check finished frames first, then predict from the pixel word
  // taken at this edge. Both channels are sampled at the rising edge only.
  always @(posedge clk) begin
    logic [MEAN_W-1:0] want;
    pix_taken <= !rst && pix_ch.valid && pix_ch.ready;
    if (!rst) begin
      if (mean_ch.valid && mean_ch.ready) begin
        if (expected_means.size() == 0) begin
          flag_error($sformatf("unexpected mean word %0d", mean_ch.mean_brightness));
        end else begin
          want = expected_means.pop_front();
          if (mean_ch.mean_brightness !== want)
            flag_error($sformatf("mean mismatch: expected %0d, got %0d",
                                 want, mean_ch.mean_brightness));
        end
      end
      if (pix_ch.valid && pix_ch.ready)
        absorb_pixel(pix_ch.pixel, pix_ch.end_of_line, pix_ch.end_of_frame);
    end
  end

  // Driver: hold a word until taken, then idle for the chosen gap or offer
  // the next queued word. A drain marker holds valid low until every
  // expected mean has come back.
  always @(negedge clk) begin
    pixel_word_t word;
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!(pix_ch.valid && !pix_taken)) begin
      if (send_gap > 0) begin
        pix_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() == 0) begin
        pix_ch.valid <= 1'b0;
      end else if (pending_words[0].drain) begin
        pix_ch.valid <= 1'b0;
        if (expected_means.size() == 0) void'(pending_words.pop_front());
      end else begin
        word = pending_words.pop_front();
        pix_ch.valid        <= 1'b1;
        pix_ch.pixel        <= word.value;
        pix_ch.end_of_line  <= word.eol;
        pix_ch.end_of_frame <= word.eof;
        send_gap <= pick_gap(send_calm);
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request so the
  // block backs up and stalls its pixel input.
  always @(negedge clk) begin
    if (rst) begin
      mean_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      mean_ch.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (hold_results_req && !holdoff_used) begin
      mean_ch.ready <= 1'b0;
      holdoff_left <= HOLDOFF;
      holdoff_used <= 1'b1;
    end else if (recv_stall > 0) begin
      mean_ch.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      mean_ch.ready <= 1'b1;
      recv_stall <= pick_gap(recv_calm);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wait until every queued word is taken and every mean is back, then let
  // the block settle before touching its registers.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || pix_ch.valid || expected_means.size() != 0);
    repeat (DRAIN_LAT) @(negedge clk);
  endtask

  // APB write: setup then access phase; the register takes the value at the
  // edge where the access phase meets pready. Junk above the field width is
  // sent half the time and must be dropped by the block.
  task automatic write_reg(input logic [2:0] idx, input int unsigned value,
                           input int width);
    logic [PDATA_W-1:0] data;
    data = PDATA_W'(value);
    if ($urandom_range(0, 1)) data = data | (PDATA_W'($urandom()) << width);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_X:  grid_cfg.start_x  = data[POS_W-1:0];
      REG_START_Y:  grid_cfg.start_y  = data[POS_W-1:0];
      REG_STRIDE_X: grid_cfg.stride_x = data[STRIDE_W-1:0];
      REG_STRIDE_Y: grid_cfg.stride_y = data[STRIDE_W-1:0];
      REG_BLOCKS_X: grid_cfg.blocks_x = data[BLOCKS_W-1:0];
      REG_BLOCKS_Y: grid_cfg.blocks_y = data[BLOCKS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int unsigned sx, input int unsigned sy,
                          input int unsigned tx, input int unsigned ty,
                          input int unsigned bx, input int unsigned by);
    wait_idle();
    write_reg(REG_START_X, sx, POS_W);
    write_reg(REG_START_Y, sy, POS_W);
    write_reg(REG_STRIDE_X, tx, STRIDE_W);
    write_reg(REG_STRIDE_Y, ty, STRIDE_W);
    write_reg(REG_BLOCKS_X, bx, BLOCKS_W);
    write_reg(REG_BLOCKS_Y, by, BLOCKS_W);
  endtask

  // Mostly a compact grid that small frames actually hit; sometimes any
  // register value at all, so every bit gets exercised.
  task automatic random_grid();
    if ($urandom_range(0, 9) < 7)
      set_grid($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 7),
               $urandom_range(0, 7), $urandom_range(0, 5), $urandom_range(0, 5));
    else
      set_grid($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 8191),
               $urandom_range(0, 8191), $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  function automatic logic [PIXEL_W-1:0] random_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIXEL_W'($urandom());
  endfunction

  task automatic push_pixel(input logic [PIXEL_W-1:0] value, input logic eol,
                            input logic eof);
    pixel_word_t word;
    word.value = value;
    word.eol   = eol;
    word.eof   = eof;
    word.drain = 1'b0;
    pending_words.push_back(word);
    queued_words++;
  endtask

  task automatic push_drain();
    pixel_word_t word;
    word.value = '0;
    word.eol   = 1'b0;
    word.eof   = 1'b0;
    word.drain = 1'b1;
    pending_words.push_back(word);
  endtask

  // Ragged random frame: each row its own length; the closing word may or
  // may not carry end of line as well.
  task automatic push_frame(input int max_w, input int max_h);
    int rows;
    int cols;
    logic closing;
    rows = $urandom_range(1, max_h);
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, max_w);
      for (int c = 0; c < cols; c++) begin
        closing = (r == rows - 1) && (c == cols - 1);
        if (closing) push_pixel(random_pixel(), $urandom_range(0, 1), 1'b1);
        else push_pixel(random_pixel(), c == cols - 1, 1'b0);
      end
    end
  endtask

  // Rectangular frame with pixels drawn from floor..255; end of frame rides
  // on the last end of line.
  task automatic push_grid_frame(input int rows, input int cols, input int floor_val);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        push_pixel($urandom_range(floor_val, 255), c == cols - 1,
                   (r == rows - 1) && (c == cols - 1));
  endtask

  initial begin
    int unsigned random_start;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pix_ch.valid        = 1'b0;
    pix_ch.pixel        = '0;
    pix_ch.end_of_line  = 1'b0;
    pix_ch.end_of_frame = 1'b0;
    mean_ch.ready       = 1'b0;
    grid_cfg.start_x    = '0;
    grid_cfg.start_y    = '0;
    grid_cfg.stride_x   = STRIDE_W'(2);
    grid_cfg.stride_y   = STRIDE_W'(2);
    grid_cfg.blocks_x   = BLOCKS_W'(1);
    grid_cfg.blocks_y   = BLOCKS_W'(1);
    scan_col            = '0;
    scan_row            = '0;
    frame_sum           = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset grid: one full cell at full scale hits all three weights.
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b1, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b1, 1'b1);
    // A lone dark pixel closes a frame without end of line.
    push_pixel(8'd0, 1'b0, 1'b1);
    push_pixel(8'd128, 1'b0, 1'b0);
    push_pixel(8'd1, 1'b0, 1'b1);

    // Odd start, strides below two and zero block counts.
    set_grid(1, 3, 0, 1, 0, 0);
    push_grid_frame(5, 4, 0);

    // Every register at its top value; nothing in a small frame is sampled.
    set_grid(4095, 4095, 8191, 8191, 4095, 4095);
    push_grid_frame(2, 2, 0);

    // Hold the result side off while a burst of tiny frames piles up.
    random_grid();
    hold_results_req = 1'b1;
    repeat (12) push_frame(3, 2);

    random_start = queued_words;
    while (queued_words < random_start + RAND_WORDS) begin
      random_grid();
      repeat ($urandom_range(1, 4)) begin
        push_frame(12, 6);
        if ($urandom_range(0, 3) == 0) push_drain();
      end
    end

    wait_idle();
    if (expected_means.size() != 0)
      flag_error($sformatf("%0d mean words never arrived", expected_means.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
